/* hw/rtl/vsp_pkg.sv */
// Shared types, register codes and constants of the V/f sine PWM block with speed loop.
`default_nettype none

package vsp_pkg;

  localparam int SINE_TABLE_SIZE_DEF = 1024;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  localparam logic [2:0] REG_SPEED_REF = 3'd0;
  localparam logic [2:0] REG_INT_GAIN  = 3'd1;
  localparam logic [2:0] REG_PROP_GAIN = 3'd2;
  localparam logic [2:0] REG_PHASE_STEP = 3'd3;
  localparam logic [2:0] REG_MOD_GAIN  = 3'd4;
  localparam logic [2:0] REG_PWM_PERIOD = 3'd5;
  localparam logic [2:0] REG_LOOP_DIV  = 3'd6;

  localparam logic signed [15:0] RST_SPEED_REF  = 16'sd150;
  localparam logic [23:0]        RST_INT_GAIN   = 24'd250;
  localparam logic [23:0]        RST_PROP_GAIN  = 24'd149914;
  localparam logic [30:0]        RST_PHASE_STEP = 31'd21474836;
  localparam logic [15:0]        RST_MOD_GAIN   = 16'd7358;
  localparam logic [15:0]        RST_PWM_PERIOD = 16'd10000;
  localparam logic [7:0]         RST_LOOP_DIV   = 8'd60;

  localparam logic signed [15:0] RST_LEVEL = 16'sd16384;
  localparam logic [31:0]        THIRD_TURN = 32'd1431655765;

  localparam logic [3:0] MUL_NONE = 4'd0;
  localparam logic [3:0] MUL_STEP = 4'd1;
  localparam logic [3:0] MUL_LG   = 4'd2;
  localparam logic [3:0] MUL_IDX  = 4'd3;
  localparam logic [3:0] MUL_SIN  = 4'd4;
  localparam logic [3:0] MUL_PLO  = 4'd5;
  localparam logic [3:0] MUL_PHI  = 4'd6;
  localparam logic [3:0] MUL_IG   = 4'd7;
  localparam logic [3:0] MUL_PG   = 4'd8;

  localparam logic [1:0] PH_A = 2'd0;
  localparam logic [1:0] PH_B = 2'd1;
  localparam logic [1:0] PH_C = 2'd2;

  typedef struct packed {
    logic signed [15:0] speed_ref;
    logic [23:0]        int_gain;
    logic [23:0]        prop_gain;
    logic [30:0]        phase_step;
    logic [15:0]        mod_gain;
    logic [15:0]        pwm_period;
    logic [7:0]         loop_div;
  } cfg_t;

  typedef struct packed {
    logic [3:0] mul_op;
    logic [1:0] ph_sel;
    logic       load_pos;
    logic       tick_start;
    logic       phase_upd;
    logic       lg_save;
    logic       sin_rd;
    logic       p_save;
    logic       acc_save;
    logic       duty_save;
    logic       integ_upd;
    logic       level_upd;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic loop_due;
  } sts_t;

endpackage

`default_nettype wire

/* hw/rtl/vf_sine_pwm_with_speed_pi.sv */
// Top level of the V/f three-phase sine PWM generator with PI speed loop.
//
//   port group   direction  carries
//   in_*         slave      one PWM tick request with the encoder position
//   out_*        master     three duty counts, loop flag and drive level
//   cfg_*        APB slave  seven configuration registers at 4*index
//
// An accepted tick runs through the phase and duty steps, plus the speed-loop steps when
// the loop runs, before out_tvalid rises; the single shared 33x25 multiplier, used
// fourteen or sixteen times a tick, sets how long a tick takes.
// A new request is taken only once the previous tick has been handed to the output
// register; a result waiting on out_tready stalls the next tick at its last step.
// rst_n is synchronous; after it the block is ready at once, with no clearing pass.
`default_nettype none

module vf_sine_pwm_with_speed_pi #(
  parameter int SINE_TABLE_SIZE = vsp_pkg::SINE_TABLE_SIZE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] encoder_position
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [15:0] duty_a, [31:16] duty_b, [47:32] duty_c,
                                       // [63:48] level_now
  output logic             out_tuser,  // [0] loop_updated
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import vsp_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  vsp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  vsp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .sts        (sts),
    .cmd        (cmd)
  );

  vsp_dp #(
    .SINE_TABLE_SIZE (SINE_TABLE_SIZE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while a tick is still in progress");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[63:48]) >= -16'sd16384 &&
                    $signed(out_tdata[63:48]) <= 16'sd16384))
    else $error("drive level outside plus or minus one half");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

endmodule

`default_nettype wire

/* hw/rtl/vsp_regs.sv */
// Configuration register file behind the APB-style port.
`default_nettype none

module vsp_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [vsp_pkg::CFG_AW-1:0] paddr,
  input  wire logic [vsp_pkg::CFG_DW-1:0] pwdata,
  output logic      [vsp_pkg::CFG_DW-1:0] prdata,
  output logic                            pready,
  output vsp_pkg::cfg_t                   cfg
);
  import vsp_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_ref  <= RST_SPEED_REF;
      cfg_r.int_gain   <= RST_INT_GAIN;
      cfg_r.prop_gain  <= RST_PROP_GAIN;
      cfg_r.phase_step <= RST_PHASE_STEP;
      cfg_r.mod_gain   <= RST_MOD_GAIN;
      cfg_r.pwm_period <= RST_PWM_PERIOD;
      cfg_r.loop_div   <= RST_LOOP_DIV;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SPEED_REF:  cfg_r.speed_ref  <= $signed(pwdata[15:0]);
        REG_INT_GAIN:   cfg_r.int_gain   <= pwdata[23:0];
        REG_PROP_GAIN:  cfg_r.prop_gain  <= pwdata[23:0];
        REG_PHASE_STEP: cfg_r.phase_step <= pwdata[30:0];
        REG_MOD_GAIN:   cfg_r.mod_gain   <= pwdata[15:0];
        REG_PWM_PERIOD: cfg_r.pwm_period <= pwdata[15:0];
        REG_LOOP_DIV:   cfg_r.loop_div   <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SPEED_REF:  prdata = {16'd0, cfg_r.speed_ref};
      REG_INT_GAIN:   prdata = {8'd0, cfg_r.int_gain};
      REG_PROP_GAIN:  prdata = {8'd0, cfg_r.prop_gain};
      REG_PHASE_STEP: prdata = {1'b0, cfg_r.phase_step};
      REG_MOD_GAIN:   prdata = {16'd0, cfg_r.mod_gain};
      REG_PWM_PERIOD: prdata = {16'd0, cfg_r.pwm_period};
      REG_LOOP_DIV:   prdata = {24'd0, cfg_r.loop_div};
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/vsp_ctrl.sv */
// Tick sequencer: steps the shared multiplier through phase, duty and speed loop work.
`default_nettype none

module vsp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic          out_tready,
  output logic               out_tvalid,
  input  wire vsp_pkg::sts_t sts,
  output vsp_pkg::cmd_t      cmd
);
  import vsp_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_INC  = 4'd1;
  localparam logic [3:0] ST_PHS  = 4'd2;
  localparam logic [3:0] ST_IDX  = 4'd3;
  localparam logic [3:0] ST_ROM  = 4'd4;
  localparam logic [3:0] ST_SIN  = 4'd5;
  localparam logic [3:0] ST_PSV  = 4'd6;
  localparam logic [3:0] ST_MLO  = 4'd7;
  localparam logic [3:0] ST_MHI  = 4'd8;
  localparam logic [3:0] ST_DUTY = 4'd9;
  localparam logic [3:0] ST_PI_I = 4'd10;
  localparam logic [3:0] ST_PI_A = 4'd11;
  localparam logic [3:0] ST_PI_L = 4'd12;
  localparam logic [3:0] ST_OUT  = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd           = '0;
    cmd.mul_op    = MUL_NONE;
    cmd.ph_sel    = ph_r;
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_pos = 1'b1;
          state_nxt    = ST_INC;
        end
      end
      ST_INC: begin
        cmd.mul_op     = MUL_STEP;
        cmd.tick_start = 1'b1;
        state_nxt      = ST_PHS;
      end
      ST_PHS: begin
        cmd.phase_upd = 1'b1;
        cmd.mul_op    = MUL_LG;
        ph_nxt        = PH_A;
        state_nxt     = ST_IDX;
      end
      ST_IDX: begin
        cmd.mul_op  = MUL_IDX;
        cmd.lg_save = (ph_r == PH_A);
        state_nxt   = ST_ROM;
      end
      ST_ROM: begin
        cmd.sin_rd = 1'b1;
        state_nxt  = ST_SIN;
      end
      ST_SIN: begin
        cmd.mul_op = MUL_SIN;
        state_nxt  = ST_PSV;
      end
      ST_PSV: begin
        cmd.p_save = 1'b1;
        state_nxt  = ST_MLO;
      end
      ST_MLO: begin
        cmd.mul_op = MUL_PLO;
        state_nxt  = ST_MHI;
      end
      ST_MHI: begin
        cmd.acc_save = 1'b1;
        cmd.mul_op   = MUL_PHI;
        state_nxt    = ST_DUTY;
      end
      ST_DUTY: begin
        cmd.duty_save = 1'b1;
        if (ph_r == PH_C) begin
          state_nxt = sts.loop_due ? ST_PI_I : ST_OUT;
        end else begin
          ph_nxt    = ph_r + 2'd1;
          state_nxt = ST_IDX;
        end
      end
      ST_PI_I: begin
        cmd.mul_op = MUL_IG;
        state_nxt  = ST_PI_A;
      end
      ST_PI_A: begin
        cmd.integ_upd = 1'b1;
        cmd.mul_op    = MUL_PG;
        state_nxt     = ST_PI_L;
      end
      ST_PI_L: begin
        cmd.level_upd = 1'b1;
        state_nxt     = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ph_r        <= PH_A;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/vsp_dp.sv */
// Datapath: phase accumulator, sine ROM, shared multiplier, duty scaling and PI speed loop.
`default_nettype none

module vsp_dp #(
  parameter int SINE_TABLE_SIZE = vsp_pkg::SINE_TABLE_SIZE_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire vsp_pkg::cfg_t cfg,
  input  wire vsp_pkg::cmd_t cmd,
  output vsp_pkg::sts_t      sts,
  input  wire logic [31:0]   in_tdata,
  output logic [63:0]        out_tdata,
  output logic               out_tuser
);
  import vsp_pkg::*;

  localparam int IDXW = $clog2(SINE_TABLE_SIZE);
  localparam logic signed [24:0] SIZE_B = 25'(SINE_TABLE_SIZE);
  localparam logic [63:0] Q30_ONE = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic signed [58:0] LIM_POS = 59'sd1073741824;
  localparam logic signed [58:0] LIM_NEG = -59'sd1073741824;
  localparam logic signed [46:0] P_BIAS = 47'sd2199023255552;

  typedef logic signed [15:0] rom_t [SINE_TABLE_SIZE];

  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] u, r, x, x2, t, s, e;
    logic [1:0]  q;
    for (int i = 0; i < SINE_TABLE_SIZE; i++) begin
      u = (64'(i) << 32) / 64'(SINE_TABLE_SIZE);
      q = u[31:30];
      r = {34'd0, u[29:0]};
      if (q[0]) begin
        r = Q30_ONE - r;
      end
      x  = (r * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd110);
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
      s  = (x * t) >> 30;
      e  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (e > 64'd32767) begin
        e = 64'd32767;
      end
      rom[i] = q[1] ? -$signed(e[15:0]) : $signed(e[15:0]);
    end
    return rom;
  endfunction

  function automatic logic signed [31:0] clamp_lvl(input logic signed [58:0] v);
    logic signed [31:0] res;
    if (v > LIM_POS) begin
      res = 32'sh4000_0000;
    end else if (v < LIM_NEG) begin
      res = 32'shC000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // architectural state
  logic [31:0]        phase_r;
  logic signed [15:0] level_r;
  logic signed [31:0] integ_r;
  logic [31:0]        prev_r;
  logic [7:0]         cd_r;
  logic               due_r;

  // working registers
  logic [31:0]        pos_r;
  logic signed [32:0] err_r;
  logic signed [57:0] mul_r;
  logic signed [31:0] lg_r;
  logic signed [15:0] sin_r;
  logic signed [46:0] p_r;
  logic [36:0]        acc_r;
  logic [15:0]        duty_a_r, duty_b_r, duty_c_r;
  logic [63:0]        out_data_r;
  logic               out_user_r;

  logic [31:0]        angle;
  logic signed [32:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [57:0] prod;
  logic [31:0]        dif;
  logic signed [32:0] err_nxt;
  logic [57:0]        duty_sum;
  logic               p_nonpos, p_big;
  logic [15:0]        duty_nxt;
  logic signed [31:0] integ_nxt;
  logic signed [31:0] lvl_nxt;
  logic [IDXW-1:0]    rom_idx;

  assign sts.loop_due = due_r;
  assign out_tdata    = out_data_r;
  assign out_tuser    = out_user_r;

  always_comb begin
    case (cmd.ph_sel)
      PH_B:    angle = phase_r + THIRD_TURN;
      PH_C:    angle = phase_r - THIRD_TURN;
      default: angle = phase_r;
    endcase
  end

  always_comb begin
    case (cmd.mul_op)
      MUL_STEP: begin
        mul_a = {2'b00, cfg.phase_step};
        mul_b = 25'(level_r);
      end
      MUL_LG: begin
        mul_a = 33'(level_r);
        mul_b = {9'd0, cfg.mod_gain};
      end
      MUL_IDX: begin
        mul_a = {1'b0, angle};
        mul_b = SIZE_B;
      end
      MUL_SIN: begin
        mul_a = 33'(lg_r);
        mul_b = 25'(sin_r);
      end
      MUL_PLO: begin
        mul_a = {12'd0, p_r[20:0]};
        mul_b = {9'd0, cfg.pwm_period};
      end
      MUL_PHI: begin
        mul_a = {12'd0, p_r[41:21]};
        mul_b = {9'd0, cfg.pwm_period};
      end
      MUL_IG: begin
        mul_a = err_r;
        mul_b = {1'b0, cfg.int_gain};
      end
      MUL_PG: begin
        mul_a = err_r;
        mul_b = {1'b0, cfg.prop_gain};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod     = 58'(mul_a) * 58'(mul_b);
  assign dif      = pos_r - prev_r;
  assign err_nxt  = 33'(cfg.speed_ref) + 33'($signed(dif));
  assign rom_idx  = mul_r[32 +: IDXW];

  assign duty_sum = {mul_r[36:0], 21'd0} + 58'(acc_r);
  assign p_nonpos = p_r[46] || (p_r == '0);
  assign p_big    = !p_r[46] && (|p_r[45:42]);
  assign duty_nxt = p_nonpos ? 16'd0 : (p_big ? cfg.pwm_period : duty_sum[57:42]);

  assign integ_nxt = clamp_lvl(59'(integ_r) + 59'(mul_r));
  assign lvl_nxt   = clamp_lvl(59'(integ_r) + 59'(mul_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      level_r <= RST_LEVEL;
      integ_r <= '0;
      prev_r  <= '0;
      cd_r    <= RST_LOOP_DIV;
      due_r   <= 1'b0;
    end else begin
      if (cmd.tick_start) begin
        cd_r  <= cd_r - 8'd1;
        due_r <= (cd_r == 8'd1);
      end
      if (cmd.phase_upd) begin
        phase_r <= phase_r + mul_r[46:15];
      end
      if (cmd.integ_upd) begin
        integ_r <= integ_nxt;
      end
      if (cmd.level_upd) begin
        level_r <= lvl_nxt[31:16];
        prev_r  <= pos_r;
        cd_r    <= cfg.loop_div;
      end
    end
  end

  always_ff @(posedge clk) begin
    mul_r <= prod;
    if (cmd.load_pos) begin
      pos_r <= in_tdata;
    end
    if (cmd.tick_start) begin
      err_r <= err_nxt;
    end
    if (cmd.lg_save) begin
      lg_r <= mul_r[31:0];
    end
    if (cmd.sin_rd) begin
      sin_r <= SINE_ROM[rom_idx];
    end
    if (cmd.p_save) begin
      p_r <= mul_r[46:0] + P_BIAS;
    end
    if (cmd.acc_save) begin
      acc_r <= mul_r[36:0];
    end
    if (cmd.duty_save) begin
      case (cmd.ph_sel)
        PH_B:    duty_b_r <= duty_nxt;
        PH_C:    duty_c_r <= duty_nxt;
        default: duty_a_r <= duty_nxt;
      endcase
    end
    if (cmd.out_load) begin
      out_data_r <= {level_r, duty_c_r, duty_b_r, duty_a_r};
      out_user_r <= due_r;
    end
  end

endmodule

`default_nettype wire

/* dv/tb_vf_sine_pwm_with_speed_pi.sv */
// Self-checking testbench for the V/f sine PWM block: predicts duties and drive level per tick.
module tb_vf_sine_pwm_with_speed_pi;
  timeunit 1ns;
  timeprecision 1ps;
  import vsp_pkg::*;

  localparam logic [2:0] REG_SPARE = 3'd7;
  localparam int RAND_PHASES = 10;
  localparam int CALM_PHASE = 2;
  localparam int PAUSE_PHASE = 4;
  localparam int DIV_ZERO_PHASE = 6;

  typedef struct {
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic [15:0] duty_c;
    logic        loop_ran;
    logic [15:0] level;
  } pwm_result_t;

  class duty_predictor;
    logic signed [15:0] sine_tab [SINE_TABLE_SIZE_DEF];
    logic [15:0] speed_ref;
    logic [23:0] int_gain;
    logic [23:0] prop_gain;
    logic [30:0] phase_step;
    logic [15:0] mod_gain;
    logic [15:0] pwm_period;
    logic [7:0]  loop_div;
    logic [31:0] phase;
    logic [31:0] prev_pos;
    logic [7:0]  countdown;
    longint      level;
    longint      integ;
    pwm_result_t awaited_ticks [$];
    int          errors;
    int          seen;

    function new();
      longint unsigned divs [5];
      longint unsigned one, u, r, x, x2, t, s, e;
      int q;
      divs = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
      one = 64'd1 << 30;
      for (int i = 0; i < SINE_TABLE_SIZE_DEF; i++) begin
        u = i;
        u = (u << 32) / SINE_TABLE_SIZE_DEF;
        q = int'((u >> 30) & 64'd3);
        r = u & (one - 1);
        if (q == 1 || q == 3) r = one - r;
        x = (r * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        t = one;
        for (int k = 0; k < 5; k++) t = one - (((x2 * t) >> 30) / divs[k]);
        s = (x * t) >> 30;
        e = (s * 64'd32767 + (64'd1 << 29)) >> 30;
        if (e > 64'd32767) e = 64'd32767;
        sine_tab[i] = (q >= 2) ? 16'(-e) : 16'(e);
      end
      speed_ref = RST_SPEED_REF;
      int_gain = RST_INT_GAIN;
      prop_gain = RST_PROP_GAIN;
      phase_step = RST_PHASE_STEP;
      mod_gain = RST_MOD_GAIN;
      pwm_period = RST_PWM_PERIOD;
      loop_div = RST_LOOP_DIV;
      phase = '0;
      prev_pos = '0;
      countdown = RST_LOOP_DIV;
      level = RST_LEVEL;
      integ = 0;
      errors = 0;
      seen = 0;
    endfunction

    static function logic [31:0] reg_mask(input logic [2:0] idx);
      case (idx)
        REG_SPEED_REF, REG_MOD_GAIN, REG_PWM_PERIOD: return 32'h0000_FFFF;
        REG_INT_GAIN, REG_PROP_GAIN: return 32'h00FF_FFFF;
        REG_PHASE_STEP: return 32'h7FFF_FFFF;
        REG_LOOP_DIV: return 32'h0000_00FF;
        default: return 32'h0;
      endcase
    endfunction

    static function longint clamp30(input longint v);
      longint lim;
      lim = longint'(1) <<< 30;
      if (v < -lim) return -lim;
      if (v > lim) return lim;
      return v;
    endfunction

    function void set_reg(input logic [2:0] idx, input logic [31:0] v);
      case (idx)
        REG_SPEED_REF: speed_ref = v[15:0];
        REG_INT_GAIN: int_gain = v[23:0];
        REG_PROP_GAIN: prop_gain = v[23:0];
        REG_PHASE_STEP: phase_step = v[30:0];
        REG_MOD_GAIN: mod_gain = v[15:0];
        REG_PWM_PERIOD: pwm_period = v[15:0];
        REG_LOOP_DIV: loop_div = v[7:0];
        default: ;
      endcase
    endfunction

    function logic [15:0] duty_for(input longint lvl, input logic [31:0] angle);
      longint unsigned ix;
      longint sn, g, p, num, d;
      ix = angle;
      ix = (ix * SINE_TABLE_SIZE_DEF) >> 32;
      sn = sine_tab[ix];
      g = mod_gain;
      p = pwm_period;
      num = lvl * g * sn * p + (p <<< 41);
      if (num <= 0) return '0;
      d = num >>> 42;
      if (d > p) d = p;
      return d[15:0];
    endfunction

    function int pending();
      return awaited_ticks.size();
    endfunction

    function void take_tick(input logic [31:0] pos);
      pwm_result_t res;
      longint stp, inc, sr, err, acc, lv, ig, pg;
      logic [31:0] du;
      stp = phase_step;
      inc = (stp * level) >>> 15;
      phase = phase + inc[31:0];
      res.duty_a = duty_for(level, phase);
      res.duty_b = duty_for(level, phase + THIRD_TURN);
      res.duty_c = duty_for(level, phase - THIRD_TURN);
      res.loop_ran = 1'b0;
      countdown = countdown - 8'd1;
      if (countdown == 8'd0) begin
        du = pos - prev_pos;
        sr = $signed(speed_ref);
        err = sr + longint'($signed(du));
        prev_pos = pos;
        ig = int_gain;
        pg = prop_gain;
        acc = clamp30(integ + ig * err);
        integ = acc;
        lv = clamp30(acc + pg * err);
        level = lv >>> 16;
        countdown = loop_div;
        res.loop_ran = 1'b1;
      end
      res.level = level[15:0];
      awaited_ticks.push_back(res);
    endfunction

    task report_mismatch(input string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task match_result(input logic [63:0] data, input logic user);
      pwm_result_t w;
      seen++;
      if (awaited_ticks.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no tick awaiting it", seen));
        return;
      end
      w = awaited_ticks.pop_front();
      if (data[15:0] !== w.duty_a)
        report_mismatch($sformatf("result %0d duty_a %0d, want %0d", seen, data[15:0], w.duty_a));
      if (data[31:16] !== w.duty_b)
        report_mismatch($sformatf("result %0d duty_b %0d, want %0d", seen, data[31:16], w.duty_b));
      if (data[47:32] !== w.duty_c)
        report_mismatch($sformatf("result %0d duty_c %0d, want %0d", seen, data[47:32], w.duty_c));
      if (user !== w.loop_ran)
        report_mismatch($sformatf("result %0d loop_updated %0b, want %0b", seen, user, w.loop_ran));
      if (data[63:48] !== w.level)
        report_mismatch($sformatf("result %0d level_now %0d, want %0d", seen,
                                  $signed(data[63:48]), $signed(w.level)));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic        out_tuser;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  duty_predictor sb;
  bit            calm;
  logic [31:0]   enc_pos;
  logic [31:0]   cfg_val [8];
  logic [31:0]   corner_pos [8];
  logic [31:0]   probe_pos [4];

  vf_sine_pwm_with_speed_pi dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("tb_vf_sine_pwm_with_speed_pi: FAIL");
    $finish;
  end

  always @(negedge clk) out_tready <= calm || ($urandom_range(99) >= 29);

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.match_result(out_tdata, out_tuser);
  end

  task automatic send_tick(input logic [31:0] pos);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 29) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= pos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.take_tick(pos);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic cfg_access(input bit wr, input logic [2:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic program_regs();
    logic [31:0] rd;
    logic [31:0] m;
    drain();
    for (int r = REG_SPEED_REF; r <= REG_LOOP_DIV; r++) begin
      cfg_access(1'b1, 3'(r), cfg_val[r], rd);
      sb.set_reg(3'(r), cfg_val[r]);
    end
    for (int r = REG_SPEED_REF; r <= REG_LOOP_DIV; r++) begin
      cfg_access(1'b0, 3'(r), '0, rd);
      m = duty_predictor::reg_mask(3'(r));
      if (((rd ^ cfg_val[r]) & m) != 0)
        sb.report_mismatch($sformatf("register %0d reads %h, want %h", r, rd & m, cfg_val[r] & m));
    end
  endtask

  task automatic load_defaults();
    cfg_val[REG_SPEED_REF] = {16'd0, RST_SPEED_REF};
    cfg_val[REG_INT_GAIN] = {8'd0, RST_INT_GAIN};
    cfg_val[REG_PROP_GAIN] = {8'd0, RST_PROP_GAIN};
    cfg_val[REG_PHASE_STEP] = {1'b0, RST_PHASE_STEP};
    cfg_val[REG_MOD_GAIN] = {16'd0, RST_MOD_GAIN};
    cfg_val[REG_PWM_PERIOD] = {16'd0, RST_PWM_PERIOD};
    cfg_val[REG_LOOP_DIV] = {24'd0, RST_LOOP_DIV};
  endtask

  function automatic logic [31:0] pick_value(input logic [31:0] lo, hi, tlo, thi);
    case ($urandom_range(5))
      0: return lo;
      1: return hi;
      2: return $urandom_range(hi, lo);
      default: return $urandom_range(thi, tlo);
    endcase
  endfunction

  task automatic draw_settings(input bit div_zero);
    case ($urandom_range(5))
      0: cfg_val[REG_SPEED_REF] = 32'h0000_8000;
      1: cfg_val[REG_SPEED_REF] = 32'h0000_7FFF;
      2: cfg_val[REG_SPEED_REF] = $urandom();
      default: cfg_val[REG_SPEED_REF] = $urandom_range(600) - 300;
    endcase
    cfg_val[REG_INT_GAIN] = pick_value(0, 32'h00FF_FFFF, 0, 2000);
    cfg_val[REG_PROP_GAIN] = pick_value(0, 32'h00FF_FFFF, 50000, 300000);
    cfg_val[REG_PHASE_STEP] = pick_value(0, 32'h7FFF_FFFF, 1000000, 60000000);
    cfg_val[REG_MOD_GAIN] = pick_value(0, 32'h0000_FFFF, 3000, 9000);
    cfg_val[REG_PWM_PERIOD] = pick_value(0, 32'h0000_FFFF, 9000, 11000);
    cfg_val[REG_LOOP_DIV] = div_zero ? 32'd0 : pick_value(1, 255, 1, 6);
    for (int r = REG_SPEED_REF; r <= REG_LOOP_DIV; r++)
      cfg_val[r] |= $urandom() & ~duty_predictor::reg_mask(3'(r));
  endtask

  initial begin
    int sr, ld, drift, spread;
    logic [31:0] rd;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    calm = 1'b0;
    enc_pos = '0;
    corner_pos = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h0000_0001, 32'h8000_0001, 32'hFFFF_FF6A, 32'h0000_0096};
    probe_pos = '{32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF};
    sb = new();
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // unused address: no register may change
    cfg_access(1'b1, REG_SPARE, $urandom(), rd);
    foreach (corner_pos[i]) send_tick(corner_pos[i]);

    cfg_val[REG_SPEED_REF] = 32'h0000_8000;
    cfg_val[REG_INT_GAIN] = 32'h00FF_FFFF;
    cfg_val[REG_PROP_GAIN] = 32'h00FF_FFFF;
    cfg_val[REG_PHASE_STEP] = 32'h7FFF_FFFF;
    cfg_val[REG_MOD_GAIN] = 32'h0000_FFFF;
    cfg_val[REG_PWM_PERIOD] = 32'h0000_FFFF;
    cfg_val[REG_LOOP_DIV] = 32'd1;
    program_regs();
    foreach (probe_pos[i]) send_tick(probe_pos[i]);

    cfg_val[REG_SPEED_REF] = 32'h0000_7FFF;
    cfg_val[REG_INT_GAIN] = 32'd0;
    cfg_val[REG_PROP_GAIN] = 32'd0;
    cfg_val[REG_PHASE_STEP] = 32'd0;
    cfg_val[REG_MOD_GAIN] = 32'd0;
    cfg_val[REG_PWM_PERIOD] = 32'd0;
    cfg_val[REG_LOOP_DIV] = 32'd255;
    program_regs();
    foreach (probe_pos[i]) send_tick(probe_pos[i]);

    load_defaults();
    cfg_val[REG_PWM_PERIOD] = 32'd1;
    cfg_val[REG_LOOP_DIV] = 32'd2;
    program_regs();
    foreach (probe_pos[i]) send_tick(probe_pos[i]);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      draw_settings(ph == DIV_ZERO_PHASE);
      program_regs();
      calm = (ph == CALM_PHASE);
      sr = $signed(cfg_val[REG_SPEED_REF][15:0]);
      ld = cfg_val[REG_LOOP_DIV][7:0];
      if (ld == 0) ld = 256;
      drift = -sr / ld;
      spread = ((drift < 0) ? -drift : drift) / 8 + 3;
      for (int n = 0; n < ((ph == DIV_ZERO_PHASE) ? 300 : 100); n++) begin
        if (ph == PAUSE_PHASE && n == 50) drain();
        if ($urandom_range(99) < 15) enc_pos = $urandom();
        else enc_pos = enc_pos + drift + $urandom_range(2 * spread) - spread;
        send_tick(enc_pos);
      end
    end
    calm = 1'b0;

    drain();
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_vf_sine_pwm_with_speed_pi: PASS");
    end else begin
      $display("tb_vf_sine_pwm_with_speed_pi: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/vsp_pkg.sv
hw/rtl/vsp_regs.sv
hw/rtl/vsp_ctrl.sv
hw/rtl/vsp_dp.sv
hw/rtl/vf_sine_pwm_with_speed_pi.sv
dv/tb_vf_sine_pwm_with_speed_pi.sv
